// ===== hdl/rrd_pkg.sv =====
// rrd_pkg: shared constants and types for the rectangular region detector
// no dependencies; imported by rrd_ctrl and rectangular_region_detect
package rrd_pkg;

  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int PIXIN_W   = 8;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int SIZE_W    = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 1'b1;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } rrd_res_t;

endpackage

// ===== hdl/rrd_ram.sv =====
// rrd_ram: pixel store, one write port and one registered read port
// no dependencies
module rrd_ram #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 8,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/rrd_ctrl.sv =====
// rrd_ctrl: query sequencer; scans row run, column run and rectangle
// at most one pixel store read per cycle while scanning; depends on rrd_pkg
module rrd_ctrl import rrd_pkg::*; #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int PIXEL_BITS = 8,
  localparam int RW = $clog2(MAX_ROWS + 1),
  localparam int CW = $clog2(MAX_COLS + 1),
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  query,
  input  logic [ROW_W-1:0]      q_row,
  input  logic [COL_W-1:0]      q_col,
  input  logic [RW-1:0]         nr,
  input  logic [CW-1:0]         nc,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [PIXEL_BITS-1:0] rd_data,
  output logic                  busy,
  output rrd_res_t              res
);

  localparam int KW = (RW > CW) ? RW : CW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_WID   = 3'd2;
  localparam logic [2:0] S_HGT   = 3'd3;
  localparam logic [2:0] S_RECT  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [RW-1:0]         r_r, r_nxt;
  logic [CW-1:0]         c_r, c_nxt;
  logic [PIXEL_BITS-1:0] v_r, v_nxt;
  logic [RW-1:0]         ir_r, ir_nxt;
  logic [CW-1:0]         ic_r, ic_nxt;
  logic [CW-1:0]         cs_r, cs_nxt;
  logic [CW-1:0]         ce_r, ce_nxt;
  logic [RW-1:0]         re_r, re_nxt;
  logic [KW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         w_r, w_nxt;
  logic [RW-1:0]         h_r, h_nxt;
  logic                  dv_r, dv_nxt;
  rrd_res_t              res_r, res_nxt;

  logic                  q_oob;
  logic                  match;
  logic                  exhausted;
  logic                  stop;
  logic                  found;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] ar, input logic [CW-1:0] ac);
    addr_of = AW'(ar) * AW'(MAX_COLS) + AW'(ac);
  endfunction

  assign q_oob     = (32'(q_row) >= 32'(nr)) || (32'(q_col) >= 32'(nc));
  assign match     = (rd_data == v_r);
  assign exhausted = (ir_r >= re_r) || (ic_r >= ce_r);
  assign stop      = (dv_r && !match) || (!dv_r && exhausted);
  assign found     = !(dv_r && !match);

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    v_nxt     = v_r;
    ir_nxt    = ir_r;
    ic_nxt    = ic_r;
    cs_nxt    = cs_r;
    ce_nxt    = ce_r;
    re_nxt    = re_r;
    cnt_nxt   = cnt_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    dv_nxt    = dv_r;
    res_nxt   = '0;
    rd_en     = 1'b0;
    rd_addr   = addr_of(ir_r, ic_r);

    case (state_r)
      S_IDLE: begin
        if (query) begin
          r_nxt = RW'(q_row);
          c_nxt = CW'(q_col);
          if (q_oob) begin
            res_nxt.valid = 1'b1;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = addr_of(RW'(q_row), CW'(q_col));
            state_nxt = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        v_nxt = rd_data;
        if (rd_data == '0) begin
          res_nxt.valid = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ir_nxt    = r_r;
          ic_nxt    = c_r + CW'(1);
          cs_nxt    = c_r;
          ce_nxt    = nc;
          re_nxt    = r_r + RW'(1);
          cnt_nxt   = '0;
          dv_nxt    = 1'b0;
          state_nxt = S_WID;
        end
      end
      S_WID, S_HGT, S_RECT: begin
        if (dv_r && match) begin
          cnt_nxt = cnt_r + KW'(1);
        end
        dv_nxt = 1'b0;
        if (!stop && !exhausted) begin
          rd_en  = 1'b1;
          dv_nxt = 1'b1;
          if (ic_r + CW'(1) >= ce_r) begin
            ic_nxt = cs_r;
            ir_nxt = ir_r + RW'(1);
          end else begin
            ic_nxt = ic_r + CW'(1);
          end
        end
        if (stop) begin
          case (state_r)
            S_WID: begin
              w_nxt     = CW'(cnt_r) + CW'(1);
              ir_nxt    = r_r + RW'(1);
              ic_nxt    = c_r;
              cs_nxt    = c_r;
              ce_nxt    = c_r + CW'(1);
              re_nxt    = nr;
              cnt_nxt   = '0;
              state_nxt = S_HGT;
            end
            S_HGT: begin
              h_nxt     = RW'(cnt_r) + RW'(1);
              ir_nxt    = r_r;
              ic_nxt    = c_r;
              cs_nxt    = c_r;
              ce_nxt    = c_r + w_r;
              re_nxt    = r_r + RW'(cnt_r) + RW'(1);
              cnt_nxt   = '0;
              state_nxt = S_RECT;
            end
            default: begin
              res_nxt.valid  = 1'b1;
              res_nxt.found  = found;
              res_nxt.width  = found ? SIZE_W'(w_r) : '0;
              res_nxt.height = found ? SIZE_W'(h_r) : '0;
              state_nxt      = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dv_r    <= 1'b0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= dv_nxt;
      res_r   <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    c_r   <= c_nxt;
    v_r   <= v_nxt;
    ir_r  <= ir_nxt;
    ic_r  <= ic_nxt;
    cs_r  <= cs_nxt;
    ce_r  <= ce_nxt;
    re_r  <= re_nxt;
    cnt_r <= cnt_nxt;
    w_r   <= w_nxt;
    h_r   <= h_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign res  = res_r;

endmodule

// ===== hdl/rectangular_region_detect.sv =====
// rectangular_region_detect: top level; dimension registers, write path,
// query sequencer and pixel store; depends on rrd_pkg, rrd_ram, rrd_ctrl
// a write request gives no result; busy stays low
// a query result strobes out_valid after acceptance, with at most one pixel store read per cycle;
// busy is low again with the result
// synchronous reset clears control state and sets both dimensions to 64; pixels stay unset
module rectangular_region_detect import rrd_pkg::*; #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int PIXEL_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_req_type,
  input  logic [ROW_W-1:0]     in_row,
  input  logic [COL_W-1:0]     in_col,
  input  logic [PIXIN_W-1:0]   in_pixel_value,
  output logic                 out_valid,
  output logic                 out_found,
  output logic [SIZE_W-1:0]    out_region_width,
  output logic [SIZE_W-1:0]    out_region_height,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  logic [CFG_W-1:0]      num_rows_r, num_rows_nxt;
  logic [CFG_W-1:0]      num_cols_r, num_cols_nxt;
  logic [RW-1:0]         nr_eff;
  logic [CW-1:0]         nc_eff;
  logic                  accept;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [PIXEL_BITS-1:0] wr_data;
  logic                  query;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [PIXEL_BITS-1:0] rd_data;
  rrd_res_t              res;

  always_comb begin
    num_rows_nxt = num_rows_r;
    num_cols_nxt = num_cols_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_ROWS: num_rows_nxt = cfg_wdata;
        CFG_NUM_COLS: num_cols_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= CFG_DIM_RESET;
      num_cols_r <= CFG_DIM_RESET;
    end else begin
      num_rows_r <= num_rows_nxt;
      num_cols_r <= num_cols_nxt;
    end
  end

  // clamp to the store size
  assign nr_eff = RW'((32'(num_rows_r) > MAX_ROWS) ? MAX_ROWS : 32'(num_rows_r));
  assign nc_eff = CW'((32'(num_cols_r) > MAX_COLS) ? MAX_COLS : 32'(num_cols_r));

  assign accept  = start && !busy;
  assign query   = accept && (in_req_type == REQ_QUERY);
  assign wr_en   = accept && (in_req_type == REQ_WRITE) &&
                   (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
  assign wr_addr = AW'(in_row) * AW'(MAX_COLS) + AW'(in_col);
  assign wr_data = PIXEL_BITS'(in_pixel_value);

  rrd_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (PIXEL_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rrd_ctrl #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .query   (query),
    .q_row   (in_row),
    .q_col   (in_col),
    .nr      (nr_eff),
    .nc      (nc_eff),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (busy),
    .res     (res)
  );

  assign out_valid         = res.valid;
  assign out_found         = res.found;
  assign out_region_width  = res.width;
  assign out_region_height = res.height;

endmodule
